// ===== rtl/dro_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the microcode program of the dead reckoning block.
// Used by dro_seq, dro_dp and dro_mul; depends on nothing.
package dro_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;

	localparam int CNT_W  = $clog2(CORDIC_STEPS);
	localparam int ZW     = ANGLE_BITS + 2;
	localparam int XW     = 33;
	localparam int TRIG_W = XW - 14;
	localparam int MA_W   = 34;
	localparam int MB_W   = 22;
	localparam int MP_W   = MA_W + MB_W;
	localparam int SD_W   = 34;
	localparam int YD_W   = 33;
	localparam int T_W    = 33;
	localparam int Q_W    = 16;
	localparam int RES_W  = 18;
	localparam int PC_W   = 5;
	localparam int ATAN_SH = 32 - ANGLE_BITS;

	localparam logic signed [XW-1:0] X_INIT = 33'sd652032874;
	localparam logic [15:0] HEADING_RST = 16'd16384;

	// round-half divisors: 8192000000 = 2^19 * 15625, 703125 for heading
	localparam logic [MP_W-1:0] HALF_POS = 56'd4096000000;
	localparam logic [MP_W-1:0] HALF_HDG = 56'd351562;
	localparam int POS_SH = 19;
	localparam logic signed [MB_W-1:0] RCP_POS = 22'sd274877;
	localparam logic signed [MB_W-1:0] RCP_HDG = 22'sd1563749;
	localparam logic signed [MB_W-1:0] DIV_POS = 22'sd15625;
	localparam logic signed [MB_W-1:0] DIV_HDG = 22'sd703125;
	localparam int RCP_SH_POS = 32;
	localparam int RCP_SH_HDG = 40;

	localparam logic [PC_W-1:0] PC_IDLE = '0;

	// arctangent of 2^-i in 2^-32 turn
	localparam logic [29:0] ATAN_TURN32 [24] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
	};

	typedef enum logic [2:0] {
		MUL_NONE, MUL_SD, MUL_YD, MUL_XC, MUL_YS, MUL_REC, MUL_BACK
	} mul_sel_t;

	typedef enum logic {DK_POS, DK_HDG} div_kind_t;

	typedef enum logic [1:0] {J_NEXT, J_IN, J_LOOP, J_OUT} jmp_t;

	typedef struct packed {
		mul_sel_t  mop;
		logic      ld;
		logic      cordic;
		logic      sv_sd;
		logic      sv_yd;
		logic      trig;
		logic      prep;
		logic      quot;
		logic      fix;
		logic      acc_x;
		logic      acc_y;
		logic      emit;
		div_kind_t dk;
		jmp_t      jmp;
	} ctl_t;

	typedef struct packed {
		logic cordic_last;
		logic out_busy;
	} stat_t;

	localparam ctl_t CTL_NOP = '{
		mop: MUL_NONE, ld: 1'b0, cordic: 1'b0, sv_sd: 1'b0, sv_yd: 1'b0,
		trig: 1'b0, prep: 1'b0, quot: 1'b0, fix: 1'b0, acc_x: 1'b0,
		acc_y: 1'b0, emit: 1'b0, dk: DK_POS, jmp: J_NEXT
	};

	function automatic logic signed [ZW-1:0] atan_step(input logic [CNT_W-1:0] i);
		logic [31:0] v;
		v = {2'b00, ATAN_TURN32[i]} + (32'd1 << (ATAN_SH - 1));
		return $signed(ZW'(v >> ATAN_SH));
	endfunction

	function automatic logic [ANGLE_BITS-1:0] heading_angle(input logic [15:0] h);
		logic [39:0] w;
		w = {h, 24'd0};
		return w[39 -: ANGLE_BITS];
	endfunction

	// microcode ROM
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t c;
		c = CTL_NOP;
		unique case (pc)
			5'd0: begin
				c.ld = 1'b1; c.jmp = J_IN;
			end
			5'd1: begin
				c.cordic = 1'b1; c.mop = MUL_SD;
			end
			5'd2: begin
				c.cordic = 1'b1; c.mop = MUL_YD; c.sv_sd = 1'b1;
			end
			5'd3: begin
				c.cordic = 1'b1; c.sv_yd = 1'b1; c.jmp = J_LOOP;
			end
			5'd4: c.trig = 1'b1;
			5'd5: c.mop = MUL_XC;
			5'd6: c.prep = 1'b1;
			5'd7: c.mop = MUL_REC;
			5'd8: c.quot = 1'b1;
			5'd9: c.mop = MUL_BACK;
			5'd10: c.fix = 1'b1;
			5'd11: begin
				c.acc_x = 1'b1; c.mop = MUL_YS;
			end
			5'd12: c.prep = 1'b1;
			5'd13: c.mop = MUL_REC;
			5'd14: c.quot = 1'b1;
			5'd15: c.mop = MUL_BACK;
			5'd16: c.fix = 1'b1;
			5'd17: begin
				c.acc_y = 1'b1; c.prep = 1'b1; c.dk = DK_HDG;
			end
			5'd18: begin
				c.mop = MUL_REC; c.dk = DK_HDG;
			end
			5'd19: begin
				c.quot = 1'b1; c.dk = DK_HDG;
			end
			5'd20: begin
				c.mop = MUL_BACK; c.dk = DK_HDG;
			end
			5'd21: begin
				c.fix = 1'b1; c.dk = DK_HDG;
			end
			5'd22: begin
				c.emit = 1'b1; c.jmp = J_OUT;
			end
			default: c.jmp = J_OUT;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/dead_reckoning_odometry.sv =====
`timescale 1ns / 1ps
// Differential-drive dead reckoning: microcode sequencer plus datapath.
// pose_valid rises at the emit step, after the CORDIC loop and the three constant divisions.
// A new tick is taken only once the sequencer is back in idle, after the CORDIC loop and the
// shared multiplier have walked the three constant divisions and the pose is emitted; pose_stall holds this off.
// Reset: asynchronous; position clears to zero, heading to a quarter turn, no pose pending.
// Depends on dro_pkg, dro_seq, dro_dp, dro_mul.
module dead_reckoning_odometry (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  logic signed [15:0]  left_wheel_speed,
	input  logic signed [15:0]  right_wheel_speed,
	input  logic signed [15:0]  yaw_rate,
	input  logic [15:0]         step_time,
	output logic                pose_valid,
	input  logic                pose_stall,
	output logic signed [31:0]  position_x,
	output logic signed [31:0]  position_y,
	output logic [15:0]         heading_angle,
	output logic signed [15:0]  mean_speed
);

	dro_pkg::ctl_t  ctl;
	dro_pkg::stat_t stat;
	logic           go;

	dro_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.stat       (stat),
		.ctl        (ctl),
		.go         (go),
		.tick_stall (tick_stall)
	);

	dro_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.go                (go),
		.left_wheel_speed  (left_wheel_speed),
		.right_wheel_speed (right_wheel_speed),
		.yaw_rate          (yaw_rate),
		.step_time         (step_time),
		.stat              (stat),
		.pose_valid        (pose_valid),
		.pose_stall        (pose_stall),
		.position_x        (position_x),
		.position_y        (position_y),
		.heading_angle     (heading_angle),
		.mean_speed        (mean_speed)
	);

endmodule

// ===== rtl/dro_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on dro_pkg.
module dro_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [dro_pkg::MA_W-1:0]   a,
	input  logic signed [dro_pkg::MB_W-1:0]   b,
	output logic signed [dro_pkg::MP_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ===== rtl/dro_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on dro_pkg.
module dro_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_valid,
	input  dro_pkg::stat_t  stat,
	output dro_pkg::ctl_t   ctl,
	output logic            go,
	output logic            tick_stall
);

	logic [dro_pkg::PC_W-1:0] pc_q;
	logic [dro_pkg::PC_W-1:0] pc_nxt;

	assign ctl = dro_pkg::ucode(pc_q);
	assign tick_stall = (pc_q != dro_pkg::PC_IDLE);

	always_comb begin
		unique case (ctl.jmp)
			dro_pkg::J_IN:  go = tick_valid;
			dro_pkg::J_OUT: go = !stat.out_busy;
			default:        go = 1'b1;
		endcase
	end

	always_comb begin
		unique case (ctl.jmp)
			dro_pkg::J_NEXT: pc_nxt = pc_q + 1'b1;
			dro_pkg::J_IN:   pc_nxt = go ? pc_q + 1'b1 : pc_q;
			dro_pkg::J_LOOP: pc_nxt = stat.cordic_last ? pc_q + 1'b1 : pc_q;
			dro_pkg::J_OUT:  pc_nxt = go ? dro_pkg::PC_IDLE : pc_q;
			default:         pc_nxt = dro_pkg::PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dro_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule

// ===== rtl/dro_dp.sv =====
`timescale 1ns / 1ps
// Datapath: CORDIC rotator, constant dividers, pose registers and output register.
// Depends on dro_pkg and dro_mul.
module dro_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dro_pkg::ctl_t       ctl,
	input  logic                go,
	input  logic signed [15:0]  left_wheel_speed,
	input  logic signed [15:0]  right_wheel_speed,
	input  logic signed [15:0]  yaw_rate,
	input  logic [15:0]         step_time,
	output dro_pkg::stat_t      stat,
	output logic                pose_valid,
	input  logic                pose_stall,
	output logic signed [31:0]  position_x,
	output logic signed [31:0]  position_y,
	output logic [15:0]         heading_angle,
	output logic signed [15:0]  mean_speed
);

	localparam int AB = dro_pkg::ANGLE_BITS;
	localparam int ZW = dro_pkg::ZW;
	localparam int XW = dro_pkg::XW;
	localparam int TW = dro_pkg::TRIG_W;
	localparam int MA_W = dro_pkg::MA_W;
	localparam int MB_W = dro_pkg::MB_W;
	localparam int MP_W = dro_pkg::MP_W;
	localparam int T_W = dro_pkg::T_W;
	localparam int Q_W = dro_pkg::Q_W;
	localparam int RES_W = dro_pkg::RES_W;

	// operands and item registers
	logic signed [16:0]                sum_q;
	logic [15:0]                       dt_q;
	logic signed [15:0]                yaw_q;
	logic signed [dro_pkg::SD_W-1:0]   sd_q;
	logic signed [dro_pkg::YD_W-1:0]   yd_q;
	logic signed [XW-1:0]              x_q;
	logic signed [XW-1:0]              y_q;
	logic signed [ZW-1:0]              z_q;
	logic                              flip_q;
	logic [dro_pkg::CNT_W-1:0]         cnt_q;
	logic signed [TW-1:0]              c_q;
	logic signed [TW-1:0]              s_q;
	logic                              neg_q;
	logic [T_W-1:0]                    t_q;
	logic [Q_W-1:0]                    q_q;
	logic signed [RES_W-1:0]           res_q;

	// architectural state and output register
	logic signed [31:0]                pos_x_q;
	logic signed [31:0]                pos_y_q;
	logic [15:0]                       heading_q;
	logic                              pose_valid_q;
	logic signed [31:0]                out_x_q;
	logic signed [31:0]                out_y_q;
	logic [15:0]                       out_h_q;
	logic signed [15:0]                out_sp_q;

	logic signed [MA_W-1:0]            ma;
	logic signed [MB_W-1:0]            mb;
	logic signed [MP_W-1:0]            prod_q;
	logic                              mul_en;
	logic signed [MB_W-1:0]            rcp;
	logic signed [MB_W-1:0]            dv;

	logic signed [XW-1:0]              xs;
	logic signed [XW-1:0]              ys;
	logic signed [ZW-1:0]              at;
	logic [AB-1:0]                     ang;
	logic                              fl;
	logic [AB-1:0]                     ang_r;
	logic signed [XW-1:0]              xf;
	logic signed [XW-1:0]              yf;
	logic signed [XW-1:0]              xr;
	logic signed [XW-1:0]              yr;

	logic signed [MP_W-1:0]            num;
	logic [MP_W-1:0]                   mag;
	logic [MP_W-1:0]                   tsum;
	logic [T_W-1:0]                    tn;
	logic [Q_W-1:0]                    qn;
	logic [T_W:0]                      rem;
	logic [T_W:0]                      dvu;
	logic [Q_W:0]                      q1;
	logic signed [RES_W-1:0]           resn;

	logic signed [31:0]                acc_base;
	logic signed [32:0]                acc_sum;
	logic signed [31:0]                acc_sat;
	logic [15:0]                       hnew;
	logic signed [16:0]                sp_sum;

	assign rcp = (ctl.dk == dro_pkg::DK_POS) ? dro_pkg::RCP_POS : dro_pkg::RCP_HDG;
	assign dv  = (ctl.dk == dro_pkg::DK_POS) ? dro_pkg::DIV_POS : dro_pkg::DIV_HDG;

	always_comb begin
		unique case (ctl.mop)
			dro_pkg::MUL_SD: begin
				ma = {{(MA_W-17){sum_q[16]}}, sum_q};
				mb = {{(MB_W-16){1'b0}}, dt_q};
			end
			dro_pkg::MUL_YD: begin
				ma = {{(MA_W-16){yaw_q[15]}}, yaw_q};
				mb = {{(MB_W-16){1'b0}}, dt_q};
			end
			dro_pkg::MUL_XC: begin
				ma = sd_q;
				mb = {{(MB_W-TW){c_q[TW-1]}}, c_q};
			end
			dro_pkg::MUL_YS: begin
				ma = sd_q;
				mb = {{(MB_W-TW){s_q[TW-1]}}, s_q};
			end
			dro_pkg::MUL_REC: begin
				ma = {{(MA_W-T_W){1'b0}}, t_q};
				mb = rcp;
			end
			dro_pkg::MUL_BACK: begin
				ma = {{(MA_W-Q_W){1'b0}}, q_q};
				mb = dv;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_en = go && (ctl.mop != dro_pkg::MUL_NONE);

	dro_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (ma),
		.b      (mb),
		.prod_q (prod_q)
	);

	// CORDIC micro-rotation
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = dro_pkg::atan_step(cnt_q);

	// second and third quadrants are turned by a half turn
	assign ang   = dro_pkg::heading_angle(heading_q);
	assign fl    = ang[AB-1] ^ ang[AB-2];
	assign ang_r = {ang[AB-1] ^ fl, ang[AB-2:0]};

	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;
	assign xr = xf + XW'(8192);
	assign yr = yf + XW'(8192);

	// round-to-nearest constant division: pre-scale, reciprocal, one correction
	assign num  = (ctl.dk == dro_pkg::DK_POS) ? prod_q :
		{{(MP_W-dro_pkg::YD_W-1){yd_q[dro_pkg::YD_W-1]}}, yd_q, 1'b0};
	assign mag  = num[MP_W-1] ? MP_W'(-num) : MP_W'(num);
	assign tsum = mag + ((ctl.dk == dro_pkg::DK_POS) ? dro_pkg::HALF_POS : dro_pkg::HALF_HDG);
	assign tn   = (ctl.dk == dro_pkg::DK_POS) ? tsum[dro_pkg::POS_SH +: T_W] : tsum[T_W-1:0];
	assign qn   = (ctl.dk == dro_pkg::DK_POS) ? prod_q[dro_pkg::RCP_SH_POS +: Q_W] :
		prod_q[dro_pkg::RCP_SH_HDG +: Q_W];
	assign rem  = {1'b0, t_q} - prod_q[T_W:0];
	assign dvu  = {{(T_W+1-MB_W){1'b0}}, dv};
	assign q1   = {1'b0, q_q} + {{Q_W{1'b0}}, (rem >= dvu)};
	assign resn = neg_q ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

	// saturating position update
	assign acc_base = ctl.acc_x ? pos_x_q : pos_y_q;
	assign acc_sum  = {acc_base[31], acc_base} + {{(33-RES_W){res_q[RES_W-1]}}, res_q};
	always_comb begin
		if (acc_sum[32] != acc_sum[31]) begin
			acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			acc_sat = acc_sum[31:0];
		end
	end

	assign hnew   = heading_q - res_q[15:0];
	assign sp_sum = sum_q + {16'd0, sum_q[16]};

	assign stat.cordic_last = (cnt_q == dro_pkg::CNT_W'(dro_pkg::CORDIC_STEPS - 1));
	assign stat.out_busy    = pose_valid_q && pose_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			heading_q    <= dro_pkg::HEADING_RST;
			pose_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (go && ctl.ld) begin
				cnt_q <= '0;
			end else if (go && ctl.cordic) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (go && (ctl.acc_x || ctl.acc_y)) begin
				if (ctl.acc_x) begin
					pos_x_q <= acc_sat;
				end else begin
					pos_y_q <= acc_sat;
				end
			end
			if (go && ctl.emit) begin
				heading_q    <= hnew;
				pose_valid_q <= 1'b1;
			end else if (pose_valid_q && !pose_stall) begin
				pose_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctl.ld) begin
			sum_q  <= {left_wheel_speed[15], left_wheel_speed} +
				{right_wheel_speed[15], right_wheel_speed};
			dt_q   <= step_time;
			yaw_q  <= yaw_rate;
			x_q    <= dro_pkg::X_INIT;
			y_q    <= '0;
			z_q    <= {{(ZW-AB){ang_r[AB-1]}}, ang_r};
			flip_q <= fl;
		end
		if (go && ctl.cordic) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (go && ctl.sv_sd) begin
			sd_q <= prod_q[dro_pkg::SD_W-1:0];
		end
		if (go && ctl.sv_yd) begin
			yd_q <= prod_q[dro_pkg::YD_W-1:0];
		end
		if (go && ctl.trig) begin
			c_q <= xr[XW-1:14];
			s_q <= yr[XW-1:14];
		end
		if (go && ctl.prep) begin
			neg_q <= num[MP_W-1];
			t_q   <= tn;
		end
		if (go && ctl.quot) begin
			q_q <= qn;
		end
		if (go && ctl.fix) begin
			res_q <= resn;
		end
		if (go && ctl.emit) begin
			out_x_q  <= pos_x_q;
			out_y_q  <= pos_y_q;
			out_h_q  <= hnew;
			out_sp_q <= sp_sum[16:1];
		end
	end

	assign pose_valid    = pose_valid_q;
	assign position_x    = out_x_q;
	assign position_y    = out_y_q;
	assign heading_angle = out_h_q;
	assign mean_speed    = out_sp_q;

endmodule

// ===== rtl/dro_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for dead_reckoning_odometry, attached by bind.
// Depends only on the top-level ports.
module dro_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                tick_valid,
	input logic                tick_stall,
	input logic                pose_valid,
	input logic                pose_stall,
	input logic signed [31:0]  position_x,
	input logic signed [31:0]  position_y,
	input logic [15:0]         heading_angle
);

	logic       tick_acc;
	logic       pose_acc;
	logic [1:0] pend_q;

	assign tick_acc = tick_valid && !tick_stall;
	assign pose_acc = pose_valid && !pose_stall;

	// ticks taken minus poses delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, tick_acc} - {1'b0, pose_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose_stall |=> pose_valid)
		else $error("pose transaction dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose_stall |=> $stable(position_x) && $stable(position_y) &&
			$stable(heading_angle))
		else $error("pose payload changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> tick_stall)
		else $error("tick accepted while previous tick in flight");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid |-> (pend_q == 2'd1 || pend_q == 2'd2))
		else $error("pose without a matching tick");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many ticks in flight");

endmodule

bind dead_reckoning_odometry dro_chk u_dro_chk (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dead_reckoning_odometry: tick transactions in, pose transactions out.
// Holds its own CORDIC and dead reckoning predictor; needs only the RTL of the block.
module testbench;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;
	localparam longint TURN     = longint'(1) << ANGLE_BITS;
	localparam longint POS_DIV  = 64'd8192000000;
	localparam longint HDG_DIV  = 64'd703125;
	localparam longint POS_MAX  = 64'd2147483647;
	localparam longint POS_MIN  = -64'sd2147483648;
	localparam int N_ROWS       = 23;
	localparam int N_RESET_ROWS = 6;
	localparam int N_RANDOM     = 1250;
	localparam int N_QUIET      = 150;

	// arctan(2^-i) in 2^-32 turn
	localparam longint ATAN_T32 [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hdg;
		logic signed [15:0] spd;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic signed [15:0] yaw;
		logic [15:0]        dt;
		logic               chk;
		pose_t              pose;
	} tick_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               tick_valid;
	logic               tick_stall;
	logic signed [15:0] left_wheel_speed;
	logic signed [15:0] right_wheel_speed;
	logic signed [15:0] yaw_rate;
	logic [15:0]        step_time;
	logic               pose_valid;
	logic               pose_stall;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic [15:0]        heading_angle;
	logic signed [15:0] mean_speed;

	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic [15:0]        est_heading;
	pose_t              pose_q[$];
	int                 mismatch_count;
	bit                 quiet;
	tick_row_t          tick_rows [N_ROWS];

	dead_reckoning_odometry i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.tick_valid        (tick_valid),
		.tick_stall        (tick_stall),
		.left_wheel_speed  (left_wheel_speed),
		.right_wheel_speed (right_wheel_speed),
		.yaw_rate          (yaw_rate),
		.step_time         (step_time),
		.pose_valid        (pose_valid),
		.pose_stall        (pose_stall),
		.position_x        (position_x),
		.position_y        (position_y),
		.heading_angle     (heading_angle),
		.mean_speed        (mean_speed)
	);

	always #2 clk = ~clk;

	function automatic longint round_div(input longint n, input longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] clamp_add(input logic signed [31:0] p, input longint d);
		longint s;
		s = longint'(p) + d;
		if (s > POS_MAX)
			s = POS_MAX;
		if (s < POS_MIN)
			s = POS_MIN;
		return s[31:0];
	endfunction

	// Q16 cosine and sine of a binary angle; quadrants 2 and 3 folded by a half turn
	function automatic void cordic_q16(input logic [15:0] h, output longint c, output longint s);
		longint x, y, z, xs, ys, t, a;
		bit flip;
		int i;
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (ANGLE_BITS >= 16)
			a = longint'(h) << (ANGLE_BITS - 16);
		else
			a = longint'(h) >> (16 - ANGLE_BITS);
		a = a & (TURN - 1);
		if (a >= TURN / 4 && a < TURN / 2 + TURN / 4) begin
			a = (a + TURN / 2) & (TURN - 1);
			flip = 1'b1;
		end
		z = (a >= TURN / 2) ? a - TURN : a;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			t = (ATAN_T32[i] + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - t;
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + t;
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + 8192) >>> 14;
		s = (y + 8192) >>> 14;
	endfunction

	function automatic pose_t dead_reckon_step(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic signed [15:0] yaw, input logic [15:0] dt);
		longint sum, span, c, s, dh, half_sum;
		pose_t p;
		sum = longint'(l) + longint'(r);
		span = longint'(dt);
		cordic_q16(est_heading, c, s);
		est_x = clamp_add(est_x, round_div(sum * span * c, POS_DIV));
		est_y = clamp_add(est_y, round_div(sum * span * s, POS_DIV));
		dh = round_div(longint'(yaw) * span * 2, HDG_DIV);
		est_heading = est_heading - dh[15:0];
		half_sum = sum / 2;
		p.x = est_x;
		p.y = est_y;
		p.hdg = est_heading;
		p.spd = half_sum[15:0];
		return p;
	endfunction

	task automatic send_tick(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic signed [15:0] yaw, input logic [15:0] dt, input bit chk, input pose_t want);
		int gap;
		pose_t pred;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid        <= 1'b1;
		left_wheel_speed  <= l;
		right_wheel_speed <= r;
		yaw_rate          <= yaw;
		step_time         <= dt;
		do
			@(posedge clk);
		while (tick_stall);
		pred = dead_reckon_step(l, r, yaw, dt);
		pose_q.push_back(chk ? want : pred);
	endtask

	task automatic send_random_tick();
		int base, diff, v;
		logic signed [15:0] l, r, yaw;
		logic [15:0] dt;
		case ($urandom_range(0, 9))
			0, 1: begin
				l = 16'($urandom);
				r = 16'($urandom);
				yaw = 16'($urandom);
				dt = 16'($urandom);
			end
			2: begin
				l = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				yaw = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				dt = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			end
			3: begin
				l = 16'($urandom);
				r = 16'($urandom);
				yaw = 16'($urandom);
				dt = '0;
			end
			default: begin
				base = $urandom_range(0, 4000);
				diff = $urandom_range(0, 600);
				v = $urandom_range(0, 6000);
				l = 16'(base - 2000 + diff - 300);
				r = 16'(base - 2000 - diff + 300);
				yaw = 16'(v - 3000);
				dt = 16'($urandom_range(500, 20000));
			end
		endcase
		send_tick(l, r, yaw, dt, 1'b0, '0);
	endtask

	// receiver back-pressure
	initial begin
		pose_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 19) == 0) begin
				pose_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				pose_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pose_t seen;
		pose_t want;
		seen = {position_x, position_y, heading_angle, mean_speed};
		if (arst_n && pose_valid && !pose_stall) begin
			if (pose_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected pose: x=%0d y=%0d hdg=%0d spd=%0d",
						seen.x, seen.y, seen.hdg, seen.spd);
				mismatch_count++;
			end else begin
				want = pose_q.pop_front();
				if (seen.x !== want.x || seen.y !== want.y || seen.hdg !== want.hdg ||
						seen.spd !== want.spd) begin
					if (mismatch_count < 10)
						$display("pose mismatch: exp x=%0d y=%0d hdg=%0d spd=%0d, got x=%0d y=%0d hdg=%0d spd=%0d",
							want.x, want.y, want.hdg, want.spd,
							seen.x, seen.y, seen.hdg, seen.spd);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int i;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		left_wheel_speed = '0;
		right_wheel_speed = '0;
		yaw_rate = '0;
		step_time = '0;
		mismatch_count = 0;
		quiet = 1'b0;
		est_x = '0;
		est_y = '0;
		est_heading = 16'd16384;
		// left, right, yaw, dt, typed check, x, y, heading, speed
		tick_rows = '{
			'{100, 200, 0, 0, 1'b1, '{0, 0, 16384, 150}},
			'{-32768, -32768, 32767, 0, 1'b1, '{0, 0, 16384, -32768}},
			'{32767, 32767, -32768, 0, 1'b1, '{0, 0, 16384, 32767}},
			'{32767, -32768, 0, 0, 1'b1, '{0, 0, 16384, 0}},
			'{-3, 0, 0, 0, 1'b1, '{0, 0, 16384, -1}},
			'{1000, 1000, 0, 1000, 1'b1, '{0, 16, 16384, 1000}},
			'{0, 0, 32767, 65535, 1'b0, '0},
			'{0, 0, -32768, 65535, 1'b0, '0},
			'{32767, 32767, 0, 65535, 1'b0, '0},
			'{-32768, -32768, 0, 65535, 1'b0, '0},
			'{32767, -32768, 16384, 40000, 1'b0, '0},
			'{1, 0, -1, 1, 1'b0, '0},
			'{20000, 20000, -32768, 65535, 1'b0, '0},
			'{-20000, 5000, -32768, 65535, 1'b0, '0},
			'{20000, 20000, -32768, 65535, 1'b0, '0},
			'{7000, 9000, -32768, 65535, 1'b0, '0},
			'{-20000, -20000, -32768, 65535, 1'b0, '0},
			'{20000, 20000, -32768, 65535, 1'b0, '0},
			'{12345, -2345, -32768, 65535, 1'b0, '0},
			'{20000, 20000, -32768, 65535, 1'b0, '0},
			'{-32768, 32767, -32768, 65535, 1'b0, '0},
			'{20000, 20000, -32768, 65535, 1'b0, '0},
			'{32767, 32767, -32768, 65535, 1'b0, '0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_RESET_ROWS; i++)
			send_tick(tick_rows[i].left, tick_rows[i].right, tick_rows[i].yaw,
				tick_rows[i].dt, tick_rows[i].chk, tick_rows[i].pose);

		for (i = N_RESET_ROWS; i < N_ROWS; i++)
			send_tick(tick_rows[i].left, tick_rows[i].right, tick_rows[i].yaw,
				tick_rows[i].dt, tick_rows[i].chk, tick_rows[i].pose);

		repeat (N_RANDOM) send_random_tick();
		quiet = 1'b1;
		repeat (N_QUIET) send_random_tick();
		tick_valid <= 1'b0;

		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
